/* rtl/depth_map_occlusion_query_unit_defines.svh */
// Assertion macros for the occlusion query unit and its checker.
`ifndef DEPTH_MAP_OCCLUSION_QUERY_UNIT_DEFINES_SVH
`define DEPTH_MAP_OCCLUSION_QUERY_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define DMOQ_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dmoq: implication check failed");

// Next-cycle implication, off during reset.
`define DMOQ_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dmoq: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define DMOQ_ASSERT_RST(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("dmoq: reset check failed");

`endif

/* rtl/dmoq_pkg.sv */
`default_nettype none
package dmoq_pkg;

  localparam int MAP_WORDS  = 4096;
  localparam int ADDR_W     = $clog2(MAP_WORDS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int COORD_BITS = 12;
  localparam int EDGE_W     = COORD_BITS + 1;
  localparam int IDX_W      = 2 * EDGE_W;
  localparam int WORD_W     = 32;
  localparam int DEPTH_LSB  = 8;
  localparam int MIP_W      = 4;
  localparam int ACT_W      = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PIXEL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BOX   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIP     = 2'd2;

  localparam logic [EDGE_W-1:0] FRAME_RESET = 13'd4096;
  localparam logic [MIP_W-1:0]  MIP_RESET   = 4'd6;
  localparam logic [WORD_W-1:0] CLEAR_WORD  = '1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_SETUP,
    ST_SCAN,
    ST_TAIL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic calc;
    logic wr;
    logic setup;
    logic issue;
    logic row_next;
    logic res_set;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_write;
    logic in_go;
    logic range_ok;
    logic last_issue;
    logic hit;
    logic row_mode;
    logic row_last;
    logic slot_free;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/dmoq_ctrl.sv */
`default_nettype none
module dmoq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  dmoq_pkg::sts_t sts,
  output dmoq_pkg::cmd_t cmd
);

  dmoq_pkg::state_t state;
  dmoq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmoq_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      dmoq_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = dmoq_pkg::ST_IDLE;
        end
      end
      dmoq_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = dmoq_pkg::ST_CALC;
        end
      end
      dmoq_pkg::ST_CALC: begin
        cmd.calc = 1'b1;
        if (sts.is_write) begin
          cmd.wr     = 1'b1;
          state_next = dmoq_pkg::ST_FINISH;
        end else if (sts.in_go) begin
          state_next = dmoq_pkg::ST_SETUP;
        end else begin
          state_next = dmoq_pkg::ST_FINISH;
        end
      end
      dmoq_pkg::ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = sts.range_ok ? dmoq_pkg::ST_SCAN : dmoq_pkg::ST_FINISH;
      end
      dmoq_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (sts.hit) begin
          cmd.res_set = 1'b1;
          state_next  = dmoq_pkg::ST_FINISH;
        end else if (sts.last_issue) begin
          state_next = dmoq_pkg::ST_TAIL;
        end
      end
      dmoq_pkg::ST_TAIL: begin
        if (sts.hit) begin
          cmd.res_set = 1'b1;
          state_next  = dmoq_pkg::ST_FINISH;
        end else if (sts.row_mode && !sts.row_last) begin
          cmd.row_next = 1'b1;
          state_next   = dmoq_pkg::ST_SETUP;
        end else begin
          state_next = dmoq_pkg::ST_FINISH;
        end
      end
      dmoq_pkg::ST_FINISH: begin
        if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = dmoq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dmoq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/dmoq_dp.sv */
`default_nettype none
module dmoq_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [dmoq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dmoq_pkg::EDGE_W-1:0]          cfg_data,
  input  logic [dmoq_pkg::ACT_W-1:0]           action,
  input  logic [dmoq_pkg::COORD_BITS-1:0]      x_min,
  input  logic [dmoq_pkg::COORD_BITS-1:0]      y_min,
  input  logic [dmoq_pkg::EDGE_W-1:0]          x_max,
  input  logic [dmoq_pkg::EDGE_W-1:0]          y_max,
  input  logic [dmoq_pkg::WORD_W-1:0]          depth_ref,
  input  logic [dmoq_pkg::ADDR_W-1:0]          word_index,
  input  logic [dmoq_pkg::WORD_W-1:0]          word_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 visible,
  input  dmoq_pkg::cmd_t                       cmd,
  output dmoq_pkg::sts_t                       sts
);

  logic [dmoq_pkg::WORD_W-1:0] mem [dmoq_pkg::MAP_WORDS];

  logic [dmoq_pkg::EDGE_W-1:0]     frame_w;
  logic [dmoq_pkg::EDGE_W-1:0]     frame_h;
  logic [dmoq_pkg::MIP_W-1:0]      mip;

  logic [dmoq_pkg::ACT_W-1:0]      act_r;
  logic [dmoq_pkg::COORD_BITS-1:0] x0_r;
  logic [dmoq_pkg::COORD_BITS-1:0] y0_r;
  logic [dmoq_pkg::EDGE_W-1:0]     x1_r;
  logic [dmoq_pkg::EDGE_W-1:0]     y1_r;
  logic [dmoq_pkg::WORD_W-1:0]     ref_r;
  logic [dmoq_pkg::ADDR_W-1:0]     widx_r;
  logic [dmoq_pkg::WORD_W-1:0]     wdata_r;

  logic [dmoq_pkg::EDGE_W-1:0]     w_r;
  logic [dmoq_pkg::CNT_W-1:0]      size_r;
  logic [dmoq_pkg::IDX_W-1:0]      p1_r;
  logic [dmoq_pkg::IDX_W-1:0]      base;
  logic [dmoq_pkg::EDGE_W-1:0]     y_r;
  logic                            wide_r;
  logic                            pix_r;

  logic [dmoq_pkg::CNT_W-1:0]      cur;
  logic [dmoq_pkg::CNT_W-1:0]      last;
  logic                            rd_valid;
  logic [dmoq_pkg::WORD_W-1:0]     q;
  logic                            res;
  logic [dmoq_pkg::ADDR_W-1:0]     clr_cnt;

  logic [dmoq_pkg::EDGE_W-1:0]     map_w;
  logic [dmoq_pkg::EDGE_W-1:0]     map_h;
  logic [dmoq_pkg::IDX_W-1:0]      size_prod;
  logic [dmoq_pkg::CNT_W-1:0]      size_next;
  logic [dmoq_pkg::IDX_W-1:0]      p0;
  logic [dmoq_pkg::IDX_W-1:0]      p1;
  logic [dmoq_pkg::EDGE_W-1:0]     span;
  logic                            in_frame;
  logic                            nonempty;
  logic [dmoq_pkg::IDX_W-1:0]      lo_full;
  logic [dmoq_pkg::IDX_W-1:0]      hi_raw;
  logic [dmoq_pkg::IDX_W-1:0]      hi_clip;

  assign map_w     = frame_w >> mip;
  assign map_h     = frame_h >> mip;
  assign size_prod = dmoq_pkg::IDX_W'(map_w) * dmoq_pkg::IDX_W'(map_h);
  assign size_next = (size_prod > dmoq_pkg::IDX_W'(dmoq_pkg::MAP_WORDS)) ?
                     dmoq_pkg::CNT_W'(dmoq_pkg::MAP_WORDS) :
                     size_prod[dmoq_pkg::CNT_W-1:0];
  assign p0        = dmoq_pkg::IDX_W'(y0_r) * dmoq_pkg::IDX_W'(map_w);
  assign p1        = dmoq_pkg::IDX_W'(y1_r - dmoq_pkg::EDGE_W'(1)) *
                     dmoq_pkg::IDX_W'(map_w);
  assign span      = x1_r - dmoq_pkg::EDGE_W'(x0_r);
  assign in_frame  = (dmoq_pkg::EDGE_W'(x0_r) < frame_w) &&
                     (dmoq_pkg::EDGE_W'(y0_r) < frame_h);
  assign nonempty  = (x1_r > dmoq_pkg::EDGE_W'(x0_r)) &&
                     (y1_r > dmoq_pkg::EDGE_W'(y0_r));

  assign lo_full = base + dmoq_pkg::IDX_W'(x0_r);
  always_comb begin
    if (pix_r) begin
      hi_raw = lo_full + dmoq_pkg::IDX_W'(1);
    end else if (wide_r) begin
      hi_raw = p1_r + dmoq_pkg::IDX_W'(x1_r);
    end else begin
      hi_raw = base + dmoq_pkg::IDX_W'(x1_r);
    end
  end
  assign hi_clip = (hi_raw > dmoq_pkg::IDX_W'(size_r)) ? dmoq_pkg::IDX_W'(size_r) : hi_raw;

  always_comb begin
    sts            = '0;
    sts.clr_last   = (clr_cnt == dmoq_pkg::ADDR_W'(dmoq_pkg::MAP_WORDS - 1));
    sts.is_write   = (act_r == dmoq_pkg::ACT_WRITE);
    sts.in_go      = ((act_r == dmoq_pkg::ACT_PIXEL) && in_frame) ||
                     ((act_r == dmoq_pkg::ACT_BOX) && nonempty);
    sts.range_ok   = (lo_full < hi_clip);
    sts.last_issue = ((cur + dmoq_pkg::CNT_W'(1)) == last);
    sts.hit        = rd_valid &&
                     (dmoq_pkg::WORD_W'(q[dmoq_pkg::WORD_W-1:dmoq_pkg::DEPTH_LSB]) >= ref_r);
    sts.row_mode   = !pix_r && !wide_r;
    sts.row_last   = ((y_r + dmoq_pkg::EDGE_W'(1)) == y1_r);
    sts.slot_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_w <= dmoq_pkg::FRAME_RESET;
      frame_h <= dmoq_pkg::FRAME_RESET;
      mip     <= dmoq_pkg::MIP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dmoq_pkg::CFG_FRAME_W: frame_w <= cfg_data;
        dmoq_pkg::CFG_FRAME_H: frame_h <= cfg_data;
        dmoq_pkg::CFG_MIP:     mip     <= cfg_data[dmoq_pkg::MIP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_cnt] <= dmoq_pkg::CLEAR_WORD;
    end else if (cmd.wr) begin
      mem[widx_r] <= wdata_r;
    end
    q <= mem[cur[dmoq_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= action;
      x0_r    <= x_min;
      y0_r    <= y_min;
      x1_r    <= x_max;
      y1_r    <= y_max;
      ref_r   <= depth_ref;
      widx_r  <= word_index;
      wdata_r <= word_data;
    end
    if (cmd.calc) begin
      w_r    <= map_w;
      size_r <= size_next;
      p1_r   <= p1;
      base   <= p0;
      y_r    <= dmoq_pkg::EDGE_W'(y0_r);
      wide_r <= (span >= map_w);
      pix_r  <= (act_r == dmoq_pkg::ACT_PIXEL);
    end else if (cmd.row_next) begin
      base <= base + dmoq_pkg::IDX_W'(w_r);
      y_r  <= y_r + dmoq_pkg::EDGE_W'(1);
    end
    if (cmd.setup) begin
      cur  <= lo_full[dmoq_pkg::CNT_W-1:0];
      last <= hi_clip[dmoq_pkg::CNT_W-1:0];
    end else if (cmd.issue) begin
      cur <= cur + dmoq_pkg::CNT_W'(1);
    end
    if (cmd.out_load) begin
      visible <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      rd_valid  <= 1'b0;
      res       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + dmoq_pkg::ADDR_W'(1);
      end
      rd_valid <= cmd.issue;
      if (cmd.load) begin
        res <= 1'b0;
      end else if (cmd.res_set) begin
        res <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/depth_map_occlusion_query_unit.sv */
// Channel  Handshake              Payload
// input    in_valid / in_stall    action, x_min, y_min, x_max, y_max, depth_ref,
//                                 word_index, word_data
// output   out_valid / out_stall  visible
// config   cfg_we                 cfg_index, cfg_data
//
// One item at a time. A write passes through load, calc and finish; a pixel
// or box test adds, for each row scanned, a setup step, one map cell read per
// scan step up to the first hit, and a tail step; the single read port of the
// depth store sets the scan rate. After reset a clearing pass fills the store
// with all ones, holding in_stall high. A result waiting on out_stall holds
// only the final step; the next item may already have been accepted.
`default_nettype none
module depth_map_occlusion_query_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dmoq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmoq_pkg::EDGE_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dmoq_pkg::ACT_W-1:0]      action,
  input  logic [dmoq_pkg::COORD_BITS-1:0] x_min,
  input  logic [dmoq_pkg::COORD_BITS-1:0] y_min,
  input  logic [dmoq_pkg::EDGE_W-1:0]     x_max,
  input  logic [dmoq_pkg::EDGE_W-1:0]     y_max,
  input  logic [dmoq_pkg::WORD_W-1:0]     depth_ref,
  input  logic [dmoq_pkg::ADDR_W-1:0]     word_index,
  input  logic [dmoq_pkg::WORD_W-1:0]     word_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            visible
);

  dmoq_pkg::cmd_t cmd;
  dmoq_pkg::sts_t sts;

  dmoq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dmoq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .action     (action),
    .x_min      (x_min),
    .y_min      (y_min),
    .x_max      (x_max),
    .y_max      (y_max),
    .depth_ref  (depth_ref),
    .word_index (word_index),
    .word_data  (word_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .visible    (visible),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire

/* rtl/dmoq_chk.sv */
`default_nettype none
`include "depth_map_occlusion_query_unit_defines.svh"
module dmoq_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic visible
);

  `DMOQ_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(visible))
  `DMOQ_ASSERT_RST(a_clear_after_reset, rst, in_stall)
  `DMOQ_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `DMOQ_ASSERT_IMP(a_result_from_busy, $rose(out_valid), $past(in_stall))

endmodule

bind depth_map_occlusion_query_unit dmoq_chk u_dmoq_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .visible   (visible)
);
`default_nettype wire

/* tb/sv/tb_depth_map_occlusion_query_unit.sv */
`timescale 1ns / 1ps
module tb_depth_map_occlusion_query_unit;
  import dmoq_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic EXP_MODEL = 1'b0;
  localparam logic EXP_TYPED = 1'b1;
  localparam int N_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 117;

  typedef struct packed {
    logic [ACT_W-1:0]      action;
    logic [COORD_BITS-1:0] x_min;
    logic [COORD_BITS-1:0] y_min;
    logic [EDGE_W-1:0]     x_max;
    logic [EDGE_W-1:0]     y_max;
    logic [WORD_W-1:0]     depth_ref;
    logic [ADDR_W-1:0]     word_index;
    logic [WORD_W-1:0]     word_data;
  } query_t;

  typedef struct packed {
    query_t q;
    logic   mode;
    logic   vis;
  } directed_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [EDGE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  query_t               in_q = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 visible;

  logic [WORD_W-1:0] depth_mem [0:MAP_WORDS-1];
  logic [EDGE_W-1:0] frame_w = FRAME_RESET;
  logic [EDGE_W-1:0] frame_h = FRAME_RESET;
  logic [MIP_W-1:0]  mip_lvl = MIP_RESET;

  logic visible_due [$];
  logic due_vis;
  int   visible_errors = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;

  int unsigned geo_fw  [N_PHASES] = '{4096, 4096, 1, 4096, 100, 640, 1, 4096, 17};
  int unsigned geo_fh  [N_PHASES] = '{4096, 4096, 1, 4096, 37, 480, 4096, 2048, 4096};
  int unsigned geo_mip [N_PHASES] = '{6, 0, 0, 12, 2, 3, 5, 5, 1};

  directed_t dir_tab [$];

  depth_map_occlusion_query_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (in_q.action),
    .x_min      (in_q.x_min),
    .y_min      (in_q.y_min),
    .x_max      (in_q.x_max),
    .y_max      (in_q.y_max),
    .depth_ref  (in_q.depth_ref),
    .word_index (in_q.word_index),
    .word_data  (in_q.word_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .visible    (visible)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  function automatic longint unsigned map_live_cells();
    longint unsigned cells;
    cells = longint'(frame_w >> mip_lvl) * longint'(frame_h >> mip_lvl);
    return (cells > MAP_WORDS) ? longint'(MAP_WORDS) : cells;
  endfunction

  function automatic logic cell_reaches(input longint unsigned idx, input logic [WORD_W-1:0] dref);
    return {8'h00, depth_mem[idx][WORD_W-1:DEPTH_LSB]} >= dref;
  endfunction

  function automatic logic span_reaches(input longint unsigned lo, input longint unsigned hi,
                                        input longint unsigned size,
                                        input logic [WORD_W-1:0] dref);
    longint unsigned i;
    if (hi > size) hi = size;
    for (i = lo; i < hi; i++)
      if (cell_reaches(i, dref)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic predict_visible(input query_t q);
    longint unsigned mw, size, x0, y0, x1, y1, row, base;
    logic vis;
    mw = frame_w >> mip_lvl;
    size = map_live_cells();
    x0 = q.x_min;
    y0 = q.y_min;
    x1 = q.x_max;
    y1 = q.y_max;
    vis = 1'b0;
    case (q.action)
      ACT_WRITE: depth_mem[q.word_index] = q.word_data;
      ACT_PIXEL: begin
        if (q.x_min < frame_w && q.y_min < frame_h) begin
          base = x0 + y0 * mw;
          if (base < size) vis = cell_reaches(base, q.depth_ref);
        end
      end
      ACT_BOX: begin
        if (x1 > x0 && y1 > y0 && size != 0) begin
          if (x1 - x0 >= mw) begin
            vis = span_reaches(x0 + y0 * mw, x1 + (y1 - 1) * mw, size, q.depth_ref);
          end else begin
            for (row = y0; row < y1 && !vis; row++) begin
              base = row * mw;
              if (x0 + base >= size) break;
              vis = span_reaches(x0 + base, x1 + base, size, q.depth_ref);
            end
          end
        end
      end
      default: ;
    endcase
    return vis;
  endfunction

  function automatic directed_t dir_row(input logic [ACT_W-1:0] act,
                                        input logic [COORD_BITS-1:0] x0, y0,
                                        input logic [EDGE_W-1:0] x1, y1,
                                        input logic [WORD_W-1:0] dref,
                                        input logic [ADDR_W-1:0] widx,
                                        input logic [WORD_W-1:0] wdata,
                                        input logic mode, input logic vis);
    directed_t d;
    d.q = '{act, x0, y0, x1, y1, dref, widx, wdata};
    d.mode = mode;
    d.vis = vis;
    return d;
  endfunction

  function automatic query_t gen_query();
    query_t q;
    int unsigned mw, mh, live, pick, lim, v, w;
    mw = frame_w >> mip_lvl;
    mh = frame_h >> mip_lvl;
    live = (mw * mh > MAP_WORDS) ? MAP_WORDS : mw * mh;
    q.action = ACT_W'($urandom);
    q.x_min = COORD_BITS'($urandom);
    q.y_min = COORD_BITS'($urandom);
    q.x_max = EDGE_W'($urandom);
    q.y_max = EDGE_W'($urandom);
    q.depth_ref = $urandom;
    q.word_index = ADDR_W'($urandom);
    q.word_data = $urandom;
    pick = $urandom_range(99);
    if (pick < 8) return q;
    case ($urandom_range(9))
      0: q.depth_ref = '0;
      1: ;
      default: q.depth_ref = {8'h00, 24'($urandom)};
    endcase
    if (pick < 45) begin
      q.action = ACT_WRITE;
      if (live != 0 && $urandom_range(4) != 0) q.word_index = ADDR_W'($urandom_range(0, live - 1));
    end else if (pick < 70) begin
      q.action = ACT_PIXEL;
      lim = $urandom_range(1) ? mw : frame_w;
      v = $urandom_range(0, lim + 1);
      q.x_min = COORD_BITS'((v > 4095) ? 4095 : v);
      lim = $urandom_range(1) ? mh : frame_h;
      v = $urandom_range(0, lim + 1);
      q.y_min = COORD_BITS'((v > 4095) ? 4095 : v);
    end else begin
      q.action = ACT_BOX;
      if ($urandom_range(63) == 0) begin
        q.x_min = '0;
        q.y_min = '0;
        q.x_max = EDGE_W'((mw > 4096) ? 4096 : mw);
        q.y_max = EDGE_W'((mh > 4096) ? 4096 : mh);
      end else begin
        v = $urandom_range(0, (mw > 4095) ? 4095 : mw);
        w = ($urandom_range(15) == 0) ? mw + $urandom_range(0, 3) : $urandom_range(0, 8);
        q.x_min = COORD_BITS'(v);
        q.x_max = EDGE_W'((v + w > 8191) ? 8191 : v + w);
        v = $urandom_range(0, (mh > 4095) ? 4095 : mh);
        q.y_min = COORD_BITS'(v);
        q.y_max = EDGE_W'(v + $urandom_range(0, 6));
      end
    end
    return q;
  endfunction

  task automatic send_item(input query_t q, input logic mode, input logic vis);
    logic predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_q <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_visible(q);
    visible_due.push_back((mode == EXP_TYPED) ? vis : predicted);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (visible_due.size() != 0);
  endtask

  task automatic load_geometry(input logic [EDGE_W-1:0] fw, input logic [EDGE_W-1:0] fh,
                               input logic [MIP_W-1:0] mip);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FRAME_W;
    cfg_data <= fw;
    @(negedge clk);
    cfg_index <= CFG_FRAME_H;
    cfg_data <= fh;
    @(negedge clk);
    cfg_index <= CFG_MIP;
    cfg_data <= EDGE_W'(mip);
    @(negedge clk);
    cfg_we <= 1'b0;
    frame_w = fw;
    frame_h = fh;
    mip_lvl = mip;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (visible_due.size() == 0) begin
        visible_errors++;
        if (visible_errors <= 10) $display("unexpected beat: visible=%0b", visible);
      end else begin
        due_vis = visible_due.pop_front();
        if (visible !== due_vis) begin
          visible_errors++;
          if (visible_errors <= 10)
            $display("visible mismatch: expected %0b, got %0b", due_vis, visible);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < MAP_WORDS; i++) depth_mem[i] = CLEAR_WORD;

    dir_tab.push_back(dir_row(ACT_PIXEL, 0, 0, 0, 0, 32'h0, 0, 0, EXP_TYPED, 1'b1));
    dir_tab.push_back(dir_row(ACT_PIXEL, 63, 63, 0, 0, 32'h00FF_FFFF, 0, 0, EXP_TYPED, 1'b1));
    dir_tab.push_back(dir_row(ACT_PIXEL, 0, 0, 0, 0, 32'h0100_0000, 0, 0, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_PIXEL, 63, 63, 0, 0, 32'hFFFF_FFFF, 0, 0, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_PIXEL, 4095, 0, 0, 0, 32'h0, 0, 0, EXP_MODEL, 1'b0));
    dir_tab.push_back(dir_row(ACT_PIXEL, 0, 4095, 0, 0, 32'h0, 0, 0, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_PIXEL, 4095, 4095, 0, 0, 32'h0, 0, 0, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_WRITE, 0, 0, 0, 0, 32'h0, 0, 32'h0, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_PIXEL, 0, 0, 0, 0, 32'h1, 0, 0, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_WRITE, 0, 0, 0, 0, 32'h0, 1, 32'h0000_00FF, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_WRITE, 0, 0, 0, 0, 32'h0, 4095, 32'h0000_0100, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_PIXEL, 63, 63, 0, 0, 32'h2, 0, 0, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_PIXEL, 63, 63, 0, 0, 32'h1, 0, 0, EXP_TYPED, 1'b1));
    dir_tab.push_back(dir_row(ACT_BOX, 0, 0, 2, 1, 32'h1, 0, 0, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_BOX, 0, 0, 3, 1, 32'h1, 0, 0, EXP_TYPED, 1'b1));
    dir_tab.push_back(dir_row(ACT_BOX, 5, 5, 5, 9, 32'h0, 0, 0, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_BOX, 5, 9, 6, 5, 32'h0, 0, 0, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_BOX, 0, 0, 4096, 4096, 32'h00FF_FFFF, 0, 0, EXP_MODEL, 1'b0));
    dir_tab.push_back(dir_row(ACT_BOX, 0, 4095, 1, 4096, 32'h0, 0, 0, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_BOX, 63, 63, 64, 64, 32'h2, 0, 0, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_BOX, 4095, 4095, 8191, 8191, 32'h0, 0, 0, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_UNUSED, 12'hFFF, 12'hFFF, 13'h1FFF, 13'h1FFF, 32'h0, 12'hFFF,
                              32'h0, EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_WRITE, 0, 0, 0, 0, 32'h0, 12'hAAA, 32'hAAAA_AAAA,
                              EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_WRITE, 0, 0, 0, 0, 32'h0, 12'h555, 32'h5555_5555,
                              EXP_TYPED, 1'b0));
    dir_tab.push_back(dir_row(ACT_PIXEL, 12'hAAA, 12'h555, 0, 0, 32'h0055_5555, 0, 0,
                              EXP_MODEL, 1'b0));

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        hold_until_drained();
        load_geometry(EDGE_W'(geo_fw[ph]), EDGE_W'(geo_fh[ph]), MIP_W'(geo_mip[ph]));
      end
      tx_idle_pct = (ph < 3) ? 24 : (ph < 6) ? 50 : 0;
      rx_idle_pct = (ph < 3) ? 50 : (ph < 6) ? 24 : 0;
      if (ph == 0)
        foreach (dir_tab[i]) send_item(dir_tab[i].q, dir_tab[i].mode, dir_tab[i].vis);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(63) == 0) hold_until_drained();
        send_item(gen_query(), EXP_MODEL, 1'b0);
      end
    end

    hold_until_drained();
    repeat (64) @(negedge clk);
    if (visible_errors == 0 && visible_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
